// ===== hw/rtl/bis_pkg.sv =====
// bis_pkg: types, widths and codes for the bilinear image scaler.
// No dependencies; imported by every module of the scaler.
`timescale 1ns / 1ps

package bis_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_SRC_DIM   = 256;               // width and height
    localparam int MAX_DST_DIM   = 4096;
    localparam int CH_N          = 4;
    localparam int SRC_AW        = $clog2(MAX_SRC_DIM);     // source coord bits
    localparam int SRC_DW        = 9;                 // src size register
    localparam int DST_DW        = 13;                // dst size register
    localparam int COORD_W       = 12;                // row/col fields
    localparam int CFG_W         = 13;                // widest register
    localparam int PROD_W        = COORD_W + SRC_AW;  // idx * (n-1)
    localparam int Q_W           = SRC_AW + FRACTION_BITS;
    localparam int DIV_W         = COORD_W;           // dst_n - 1
    localparam int W_W           = 2 * FRACTION_BITS + 1;
    localparam int WP_W          = 2 * (FRACTION_BITS + 1);
    localparam int PRD_W         = W_W + 8;
    localparam int ACC_W         = PRD_W + 2;
    localparam int PIX_W         = 8 * CH_N;
    localparam int BANK_AW       = 2 * (SRC_AW - 1);
    localparam logic [7:0] METHOD_BILINEAR = 8'd1;

    // Any unsupported method value maps to one code, ST_METHOD
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_METHOD = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_SRC_W  = 3'd0,
        CFG_SRC_H  = 3'd1,
        CFG_DST_W  = 3'd2,
        CFG_DST_H  = 3'd3,
        CFG_CHAN   = 3'd4,
        CFG_METHOD = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [7:0]         sample_in_0;
        logic [7:0]         sample_in_1;
        logic [7:0]         sample_in_2;
        logic [7:0]         sample_in_3;
    } t_in;

    typedef struct packed {
        logic [7:0] sample_out_0;
        logic [7:0] sample_out_1;
        logic [7:0] sample_out_2;
        logic [7:0] sample_out_3;
        t_status    status;
    } t_out;

    // What travels beside the coordinates down the pipe
    typedef struct packed {
        logic              req;
        t_status           status;
        logic [SRC_AW-1:0] wrow;
        logic [SRC_AW-1:0] wcol;
        logic [PIX_W-1:0]  wdata;
    } t_side;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [SRC_AW-1:0] lo;
        logic [Q_W-1:0]    q;
    } t_dhalf;

    typedef struct packed {
        t_dhalf r;
        t_dhalf c;
    } t_dstep;

endpackage

// ===== hw/rtl/bilinear_image_scaler_core.sv =====
// bilinear_image_scaler_core: corner-aligned bilinear resize, top level.
// Uses bis_pkg, bis_div, bis_bank, bis_lane.
// Accepts one beat per cycle unless a held result stalls the whole pipe.
// Throughput is one item per cycle when not stalled: divider is fully
// pipelined, source store split into four parity banks, one neighbour read each.
// Synchronous active-low reset loads the configuration defaults and clears pipe valids only.
`timescale 1ns / 1ps

module bilinear_image_scaler_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [bis_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bis_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bis_pkg::t_out             o_out_data
);
    import bis_pkg::*;

    // ---- configuration registers ----
    logic [SRC_DW-1:0] r_src_w, r_src_h;
    logic [DST_DW-1:0] r_dst_w, r_dst_h;
    logic [2:0]        r_chan;
    logic [7:0]        r_method;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SRC_DW'(2);
            r_src_h  <= SRC_DW'(2);
            r_dst_w  <= DST_DW'(2);
            r_dst_h  <= DST_DW'(2);
            r_chan   <= 3'd3;
            r_method <= METHOD_BILINEAR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_W:  r_src_w  <= i_cfg_wdata[SRC_DW-1:0];
                CFG_SRC_H:  r_src_h  <= i_cfg_wdata[SRC_DW-1:0];
                CFG_DST_W:  r_dst_w  <= i_cfg_wdata[DST_DW-1:0];
                CFG_DST_H:  r_dst_h  <= i_cfg_wdata[DST_DW-1:0];
                CFG_CHAN:   r_chan   <= i_cfg_wdata[2:0];
                CFG_METHOD: r_method <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Effective (clamped) sizes; the user must change registers only while idle, the block does not enforce it
    logic [SRC_DW-1:0] sw, sh;
    logic [DST_DW-1:0] dw, dh;
    logic [2:0]        nch;
    logic [SRC_AW-1:0] sw_m1, sh_m1;
    logic [DIV_W-1:0]  dw_m1, dh_m1;

    always_comb begin
        sw  = (r_src_w < SRC_DW'(2)) ? SRC_DW'(2) :
              (r_src_w > SRC_DW'(MAX_SRC_DIM)) ? SRC_DW'(MAX_SRC_DIM) : r_src_w;
        sh  = (r_src_h < SRC_DW'(2)) ? SRC_DW'(2) :
              (r_src_h > SRC_DW'(MAX_SRC_DIM)) ? SRC_DW'(MAX_SRC_DIM) : r_src_h;
        dw  = (r_dst_w < DST_DW'(2)) ? DST_DW'(2) :
              (r_dst_w > DST_DW'(MAX_DST_DIM)) ? DST_DW'(MAX_DST_DIM) : r_dst_w;
        dh  = (r_dst_h < DST_DW'(2)) ? DST_DW'(2) :
              (r_dst_h > DST_DW'(MAX_DST_DIM)) ? DST_DW'(MAX_DST_DIM) : r_dst_h;
        nch = (r_chan < 3'd1) ? 3'd1 : (r_chan > 3'(CH_N)) ? 3'(CH_N) : r_chan;
        sw_m1 = SRC_AW'(sw - SRC_DW'(1));
        sh_m1 = SRC_AW'(sh - SRC_DW'(1));
        dw_m1 = DIV_W'(dw - DST_DW'(1));
        dh_m1 = DIV_W'(dh - DST_DW'(1));
    end

    // ---- flow control: whole pipe moves unless the result register is held ----
    logic r_out_valid;
    logic en;
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---- stage 1: classify beat, scale index by (n-1) ----
    logic              r1_vld;
    t_side             r1_side, n1_side;
    logic [PROD_W-1:0] r1_p_r, r1_p_c;
    logic              n1_vld;

    always_comb begin
        n1_side.req   = i_in_data.mode;
        n1_side.wrow  = i_in_data.row[SRC_AW-1:0];
        n1_side.wcol  = i_in_data.col[SRC_AW-1:0];
        n1_side.wdata = {i_in_data.sample_in_3, i_in_data.sample_in_2,
                         i_in_data.sample_in_1, i_in_data.sample_in_0};
        if (r_method != METHOD_BILINEAR)
            n1_side.status = ST_METHOD;
        else if (DST_DW'(i_in_data.row) >= dh || DST_DW'(i_in_data.col) >= dw)
            n1_side.status = ST_RANGE;
        else
            n1_side.status = ST_OK;
        // loads outside storage are dropped here
        n1_vld = i_in_valid && (i_in_data.mode ||
                 (i_in_data.row < COORD_W'(MAX_SRC_DIM) &&
                  i_in_data.col < COORD_W'(MAX_SRC_DIM)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r1_vld <= 1'b0;
        else if (en)
            r1_vld <= n1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side <= n1_side;
            r1_p_r  <= PROD_W'(i_in_data.row) * PROD_W'(sh_m1);
            r1_p_c  <= PROD_W'(i_in_data.col) * PROD_W'(sw_m1);
        end
    end

    // ---- map: Q16 source position = (p << 16) / (dst_n - 1) ----
    logic           d_vld;
    t_side          d_side;
    logic [Q_W-1:0] d_q_r, d_q_c;

    bis_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r1_vld),
        .i_side (r1_side),
        .i_p_r  (r1_p_r),
        .i_p_c  (r1_p_c),
        .i_d_r  (dh_m1),
        .i_d_c  (dw_m1),
        .o_vld  (d_vld),
        .o_side (d_side),
        .o_q_r  (d_q_r),
        .o_q_c  (d_q_c)
    );

    // ---- stage A: neighbour rows/cols, clamped at the last one ----
    logic                     ra_vld;
    t_side                    ra_side;
    logic [SRC_AW-1:0]        ra_r0, ra_r1, ra_c0, ra_c1;
    logic [FRACTION_BITS-1:0] ra_fy, ra_fx;
    logic [SRC_AW-1:0]        na_r0, na_c0;

    assign na_r0 = (d_q_r[Q_W-1:FRACTION_BITS] > sh_m1) ? sh_m1 : d_q_r[Q_W-1:FRACTION_BITS];
    assign na_c0 = (d_q_c[Q_W-1:FRACTION_BITS] > sw_m1) ? sw_m1 : d_q_c[Q_W-1:FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            ra_vld <= 1'b0;
        else if (en)
            ra_vld <= d_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_side <= d_side;
            ra_r0   <= na_r0;
            ra_c0   <= na_c0;
            ra_r1   <= (na_r0 < sh_m1) ? na_r0 + SRC_AW'(1) : na_r0;
            ra_c1   <= (na_c0 < sw_m1) ? na_c0 + SRC_AW'(1) : na_c0;
            ra_fy   <= d_q_r[FRACTION_BITS-1:0];
            ra_fx   <= d_q_c[FRACTION_BITS-1:0];
        end
    end

    // ---- stage B: four parity banks (row lsb, col lsb), weights ----
    // Loads write here, in beat order with the reads of requests.
    logic [PIX_W-1:0]   rd [4];
    logic [BANK_AW-1:0] raddr [4];
    logic               bank_we [4];
    logic [BANK_AW-1:0] waddr;

    assign waddr = {ra_side.wrow[SRC_AW-1:1], ra_side.wcol[SRC_AW-1:1]};

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [SRC_AW-1:0] rr, cc;
        assign rr = (ra_r0[0] == b[1]) ? ra_r0 : ra_r1;
        assign cc = (ra_c0[0] == b[0]) ? ra_c0 : ra_c1;
        assign raddr[b]   = {rr[SRC_AW-1:1], cc[SRC_AW-1:1]};
        assign bank_we[b] = en && ra_vld && !ra_side.req
                         && ra_side.wrow[0] == b[1] && ra_side.wcol[0] == b[0];

        bis_bank u_bank (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_we   (bank_we[b]),
            .i_waddr(waddr),
            .i_wdata(ra_side.wdata),
            .i_raddr(raddr[b]),
            .o_rdata(rd[b])
        );
    end

    logic [FRACTION_BITS:0] omfx, omfy;
    logic [WP_W-1:0]        m00, m01, m10, m11;
    assign omfx = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, ra_fx};
    assign omfy = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, ra_fy};
    assign m00  = WP_W'(omfx) * WP_W'(omfy);
    assign m01  = WP_W'(ra_fx) * WP_W'(omfy);
    assign m10  = WP_W'(omfx) * WP_W'(ra_fy);
    assign m11  = WP_W'(ra_fx) * WP_W'(ra_fy);

    logic           rb_vld;
    t_side          rb_side;
    logic [W_W-1:0] rb_w [4];
    logic           rb_r0p, rb_r1p, rb_c0p, rb_c1p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            rb_vld <= 1'b0;
        else if (en)
            rb_vld <= ra_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_side <= ra_side;
            rb_w[0] <= W_W'(m00);
            rb_w[1] <= W_W'(m01);
            rb_w[2] <= W_W'(m10);
            rb_w[3] <= W_W'(m11);
            rb_r0p  <= ra_r0[0];
            rb_r1p  <= ra_r1[0];
            rb_c0p  <= ra_c0[0];
            rb_c1p  <= ra_c1[0];
        end
    end

    // neighbour words: 00, 01 (next col), 10 (next row), 11
    logic [PIX_W-1:0] nb [4];
    assign nb[0] = rd[{rb_r0p, rb_c0p}];
    assign nb[1] = rd[{rb_r0p, rb_c1p}];
    assign nb[2] = rd[{rb_r1p, rb_c0p}];
    assign nb[3] = rd[{rb_r1p, rb_c1p}];

    // ---- channel lanes, two stages each ----
    logic [7:0] lane_out [CH_N];

    for (genvar k = 0; k < CH_N; k++) begin : g_lane
        logic [7:0] pix [4];
        for (genvar j = 0; j < 4; j++) begin : g_pix
            assign pix[j] = nb[j][8*k +: 8];
        end
        bis_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pix   (pix),
            .i_w     (rb_w),
            .o_sample(lane_out[k])
        );
    end

    logic  rc1_vld, rc2_vld;
    t_side rc1_side, rc2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc1_vld <= 1'b0;
            rc2_vld <= 1'b0;
        end else if (en) begin
            rc1_vld <= rb_vld;
            rc2_vld <= rc1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc1_side <= rb_side;
            rc2_side <= rc1_side;
        end
    end

    // ---- merge: mask unused channels and failed requests ----
    t_out r_out, n_out;
    logic [7:0] smp [CH_N];

    always_comb begin
        for (int k = 0; k < CH_N; k++)
            smp[k] = (rc2_side.status == ST_OK && 3'(k) < nch) ? lane_out[k] : 8'd0;
        n_out.sample_out_0 = smp[0];
        n_out.sample_out_1 = smp[1];
        n_out.sample_out_2 = smp[2];
        n_out.sample_out_3 = smp[3];
        n_out.status       = rc2_side.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (en)
            r_out_valid <= rc2_vld && rc2_side.req;
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks ----
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.sample_out_0 == 8'd0 && o_out_data.sample_out_1 == 8'd0 &&
         o_out_data.sample_out_2 == 8'd0 && o_out_data.sample_out_3 == 8'd0))
        else $error("error beat carries samples");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && rc2_vld && !rc2_side.req) |=> !o_out_valid)
        else $error("load beat produced a result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without held result");

    a_no_write_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> !(bank_we[0] || bank_we[1] || bank_we[2] || bank_we[3]))
        else $error("bank write while pipe held");

endmodule

// ===== hw/rtl/bis_div.sv =====
// bis_div: pipelined restoring divider, one quotient bit per stage, row and
// column side by side. Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  bis_pkg::t_side             i_side,
    input  logic [bis_pkg::PROD_W-1:0] i_p_r,
    input  logic [bis_pkg::PROD_W-1:0] i_p_c,
    input  logic [bis_pkg::DIV_W-1:0]  i_d_r,
    input  logic [bis_pkg::DIV_W-1:0]  i_d_c,
    output logic                       o_vld,
    output bis_pkg::t_side             o_side,
    output logic [bis_pkg::Q_W-1:0]    o_q_r,
    output logic [bis_pkg::Q_W-1:0]    o_q_c
);
    import bis_pkg::*;

    function automatic t_dhalf step(input t_dhalf s, input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic           ge;
        t_dhalf         o;
        t  = {s.rem, s.lo[SRC_AW-1]};
        ge = (t >= {1'b0, d});
        o.rem = ge ? DIV_W'(t - {1'b0, d}) : t[DIV_W-1:0];
        o.lo  = s.lo << 1;
        o.q   = {s.q[Q_W-2:0], ge};
        return o;
    endfunction

    t_dstep init;
    t_dstep n_st [Q_W];
    t_dstep r_st [Q_W];
    t_side  r_side [Q_W];
    logic   r_vld [Q_W];

    // Top bits of the numerator are already below the divisor
    assign init.r = '{rem: i_p_r[PROD_W-1:SRC_AW], lo: i_p_r[SRC_AW-1:0], q: '0};
    assign init.c = '{rem: i_p_c[PROD_W-1:SRC_AW], lo: i_p_c[SRC_AW-1:0], q: '0};

    always_comb begin
        for (int i = 0; i < Q_W; i++) begin
            if (i == 0) begin
                n_st[i].r = step(init.r, i_d_r);
                n_st[i].c = step(init.c, i_d_c);
            end else begin
                n_st[i].r = step(r_st[i-1].r, i_d_r);
                n_st[i].c = step(r_st[i-1].c, i_d_c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Q_W; i++) r_vld[i] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < Q_W; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int i = 1; i < Q_W; i++) r_side[i] <= r_side[i-1];
            for (int i = 0; i < Q_W; i++) r_st[i] <= n_st[i];
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q_r  = r_st[Q_W-1].r.q;
    assign o_q_c  = r_st[Q_W-1].c.q;

endmodule

// ===== hw/rtl/bis_bank.sv =====
// bis_bank: one source pixel bank, one write and one registered read port.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_bank (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [bis_pkg::BANK_AW-1:0] i_waddr,
    input  logic [bis_pkg::PIX_W-1:0]   i_wdata,
    input  logic [bis_pkg::BANK_AW-1:0] i_raddr,
    output logic [bis_pkg::PIX_W-1:0]   o_rdata
);
    import bis_pkg::*;

    logic [PIX_W-1:0] mem [2**BANK_AW];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bis_lane.sv =====
// bis_lane: blend of one channel, four products then a registered sum.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_lane (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [7:0]              i_pix [4],
    input  logic [bis_pkg::W_W-1:0] i_w   [4],
    output logic [7:0]              o_sample
);
    import bis_pkg::*;

    logic [PRD_W-1:0] r_prod [4];
    logic [ACC_W-1:0] acc;
    logic [7:0]       r_sample;

    assign acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1])
               + ACC_W'(r_prod[2]) + ACC_W'(r_prod[3]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) r_prod[i] <= PRD_W'(i_pix[i]) * PRD_W'(i_w[i]);
            r_sample <= acc[2*FRACTION_BITS +: 8];
        end
    end

    assign o_sample = r_sample;

endmodule

// ===== test/tb_bilinear_image_scaler_core.sv =====
// tb_bilinear_image_scaler_core: self-checking bench for the bilinear scaler.
// Directed table then phased random traffic, checked against an internal predictor.
// Depends on bis_pkg and bilinear_image_scaler_core.
`timescale 1ns / 1ps

module tb_bilinear_image_scaler_core;
    import bis_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam int DRAIN    = 40;     // longer than the pipeline of the top level
    localparam int N_PHASES = 12;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in                 i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out                o_out_data;

    bilinear_image_scaler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Shadow of the block: registers, source store, and which pixels hold data
    logic [12:0] reg_sw, reg_sh, reg_dw, reg_dh, reg_ch, reg_meth;
    logic [31:0] src_store [0:65535];
    bit          src_written [0:65535];
    t_out        pending_pixels [$];

    int  errors;
    int  idle_cycles;
    int  n_sent;
    int  rx_wait, rx_max, rx_hold;
    bit  rx_hold_req, rx_hold_done;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;
    t_row directed [$];

    function automatic int clampi(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Corner-aligned mapping of a destination pixel onto its four neighbours
    function automatic void map_point(input logic [11:0] row, input logic [11:0] col,
                                      output int r0, output int c0,
                                      output int r1, output int c1,
                                      output longint unsigned fy,
                                      output longint unsigned fx);
        int sw, sh, dw, dh;
        longint unsigned py, px;
        sw = clampi(reg_sw, 2, 256);
        sh = clampi(reg_sh, 2, 256);
        dw = clampi(reg_dw, 2, 4096);
        dh = clampi(reg_dh, 2, 4096);
        py = ((longint'(row) * (sh - 1)) << FRACTION_BITS) / (dh - 1);
        px = ((longint'(col) * (sw - 1)) << FRACTION_BITS) / (dw - 1);
        r0 = clampi(int'(py >> FRACTION_BITS), 0, sh - 1);
        c0 = clampi(int'(px >> FRACTION_BITS), 0, sw - 1);
        fy = py & 64'hFFFF;
        fx = px & 64'hFFFF;
        r1 = (r0 + 1 < sh) ? r0 + 1 : r0;
        c1 = (c0 + 1 < sw) ? c0 + 1 : c0;
    endfunction

    function automatic bit in_dst(logic [11:0] row, logic [11:0] col);
        return row < clampi(reg_dh, 2, 4096) && col < clampi(reg_dw, 2, 4096);
    endfunction

    // Applies one beat to the shadow; returns 1 when it yields a result
    function automatic bit scale_pixel(input t_in it, output t_out res);
        int r0, c0, r1, c1, nch;
        longint unsigned fy, fx, w00, w01, w10, w11, acc, one;
        logic [7:0] s [4];
        res = '0;
        if (it.mode == 1'b0) begin
            if (it.row < 256 && it.col < 256) begin
                src_store[it.row * 256 + it.col] = {it.sample_in_3, it.sample_in_2,
                                                    it.sample_in_1, it.sample_in_0};
                src_written[it.row * 256 + it.col] = 1'b1;
            end
            return 1'b0;
        end
        if (reg_meth[7:0] != METHOD_BILINEAR) begin
            res.status = ST_METHOD;
            return 1'b1;
        end
        if (!in_dst(it.row, it.col)) begin
            res.status = ST_RANGE;
            return 1'b1;
        end
        map_point(it.row, it.col, r0, c0, r1, c1, fy, fx);
        one = 64'd1 << FRACTION_BITS;
        w00 = (one - fx) * (one - fy);
        w01 = fx * (one - fy);
        w10 = (one - fx) * fy;
        w11 = fx * fy;
        nch = clampi(reg_ch, 1, 4);
        for (int k = 0; k < 4; k++) begin
            s[k] = 8'd0;
            if (k < nch) begin
                acc = longint'(src_store[r0 * 256 + c0][8*k +: 8]) * w00
                    + longint'(src_store[r0 * 256 + c1][8*k +: 8]) * w01
                    + longint'(src_store[r1 * 256 + c0][8*k +: 8]) * w10
                    + longint'(src_store[r1 * 256 + c1][8*k +: 8]) * w11;
                s[k] = acc[2*FRACTION_BITS +: 8];
            end
        end
        res.sample_out_0 = s[0];
        res.sample_out_1 = s[1];
        res.sample_out_2 = s[2];
        res.sample_out_3 = s[3];
        res.status = ST_OK;
        return 1'b1;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Output monitor, idle watchdog and receiver wait draw
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired at %0t", $realtime);
            $display("bilinear_image_scaler_core regression: fail");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rx_wait = $urandom_range(0, rx_max);
            if (pending_pixels.size() == 0) begin
                report("unexpected beat", 8'(o_out_data.status), 8'd0);
            end else begin
                w = pending_pixels.pop_front();
                if (o_out_data.sample_out_0 !== w.sample_out_0)
                    report("sample_out_0", o_out_data.sample_out_0, w.sample_out_0);
                if (o_out_data.sample_out_1 !== w.sample_out_1)
                    report("sample_out_1", o_out_data.sample_out_1, w.sample_out_1);
                if (o_out_data.sample_out_2 !== w.sample_out_2)
                    report("sample_out_2", o_out_data.sample_out_2, w.sample_out_2);
                if (o_out_data.sample_out_3 !== w.sample_out_3)
                    report("sample_out_3", o_out_data.sample_out_3, w.sample_out_3);
                if (o_out_data.status !== w.status)
                    report("status", 8'(o_out_data.status), 8'(w.status));
            end
        end
    end

    // Receiver: per-beat random stall, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold = 300;
            rx_hold_done = 1'b1;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Offers one beat at a falling edge and returns at the falling edge after acceptance
    task automatic send_beat(t_in it, bit typed, t_out want);
        t_out p;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (scale_pixel(it, p))
            pending_pixels.push_back(typed ? want : p);
        @(negedge i_clk);
    endtask

    task automatic gap(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // One write beat, then a wait with the enable low so enables never collide
    task automatic write_reg(t_cfg_idx idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SRC_W:  reg_sw   = 13'(val & 9'h1FF);
            CFG_SRC_H:  reg_sh   = 13'(val & 9'h1FF);
            CFG_DST_W:  reg_dw   = 13'(val & 13'h1FFF);
            CFG_DST_H:  reg_dh   = 13'(val & 13'h1FFF);
            CFG_CHAN:   reg_ch   = 13'(val & 3'h7);
            CFG_METHOD: reg_meth = 13'(val & 8'hFF);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_in pix(bit m, int r, int c, int s0, int s1, int s2, int s3);
        t_in it;
        it.mode = m;
        it.row = 12'(r);
        it.col = 12'(c);
        it.sample_in_0 = 8'(s0);
        it.sample_in_1 = 8'(s1);
        it.sample_in_2 = 8'(s2);
        it.sample_in_3 = 8'(s3);
        return it;
    endfunction

    function automatic t_in rand_load(int r, int c);
        return pix(1'b0, r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic t_out res(int s0, int s1, int s2, int s3, t_status st);
        t_out o;
        o.sample_out_0 = 8'(s0);
        o.sample_out_1 = 8'(s1);
        o.sample_out_2 = 8'(s2);
        o.sample_out_3 = 8'(s3);
        o.status = st;
        return o;
    endfunction

    task automatic add_row(t_in it, bit typed, t_out want);
        t_row r;
        r.item = it;
        r.typed = typed;
        r.want = want;
        directed.push_back(r);
    endtask

    // Loads any neighbour a request would read before it has been written
    task automatic fill_neighbours(logic [11:0] row, logic [11:0] col, int gmax);
        int r [4];
        int c [4];
        longint unsigned fy, fx;
        map_point(row, col, r[0], c[0], r[3], c[3], fy, fx);
        r[1] = r[0]; c[1] = c[3];
        r[2] = r[3]; c[2] = c[0];
        for (int k = 0; k < 4; k++) begin
            if (!src_written[r[k] * 256 + c[k]]) begin
                send_beat(rand_load(r[k], c[k]), 1'b0, '0);
                gap($urandom_range(0, gmax));
            end
        end
    endtask

    task automatic drain_idle;
        gap(1);
        wait (pending_pixels.size() == 0);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    initial begin
        int cfg [6];
        int gmax, n_items, pick, base;
        bit paused;
        logic [11:0] row, col;
        t_in it;

        errors = 0;
        idle_cycles = 0;
        n_sent = 0;
        rx_wait = 0;
        rx_max = 11;
        rx_hold = 0;
        rx_hold_req = 1'b0;
        rx_hold_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SRC_W;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        reg_sw = 2; reg_sh = 2; reg_dw = 2; reg_dh = 2; reg_ch = 3; reg_meth = 1;
        for (int a = 0; a < 65536; a++) begin
            src_store[a] = '0;
            src_written[a] = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset settings: 2x2 source onto 2x2 destination, three channels
        add_row(pix(0, 0, 0, 0, 255, 0, 255), 0, '0);
        add_row(pix(0, 0, 1, 255, 0, 255, 0), 0, '0);
        add_row(pix(0, 1, 0, 17, 34, 51, 68), 0, '0);
        add_row(pix(0, 1, 1, 255, 255, 255, 255), 0, '0);
        add_row(pix(1, 0, 0, 0, 0, 0, 0), 1, res(0, 255, 0, 0, ST_OK));
        add_row(pix(1, 0, 1, 0, 0, 0, 0), 1, res(255, 0, 255, 0, ST_OK));
        add_row(pix(1, 1, 0, 0, 0, 0, 0), 1, res(17, 34, 51, 0, ST_OK));
        add_row(pix(1, 1, 1, 255, 255, 255, 255), 1, res(255, 255, 255, 0, ST_OK));
        // loads beyond the store are dropped
        add_row(pix(0, 256, 0, 1, 2, 3, 4), 0, '0);
        add_row(pix(0, 0, 256, 1, 2, 3, 4), 0, '0);
        add_row(pix(0, 4095, 4095, 255, 255, 255, 255), 0, '0);
        add_row(pix(1, 0, 0, 0, 0, 0, 0), 1, res(0, 255, 0, 0, ST_OK));
        // requests outside the destination
        add_row(pix(1, 2, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, ST_RANGE));
        add_row(pix(1, 0, 2, 0, 0, 0, 0), 1, res(0, 0, 0, 0, ST_RANGE));
        add_row(pix(1, 4095, 4095, 255, 255, 255, 255), 1, res(0, 0, 0, 0, ST_RANGE));
        foreach (directed[i]) begin
            send_beat(directed[i].item, directed[i].typed, directed[i].want);
            gap($urandom_range(0, 3));
        end
        drain_idle();

        // Unsupported method wins over the range check
        write_reg(CFG_METHOD, 0);
        send_beat(pix(1, 4095, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, ST_METHOD));
        send_beat(pix(1, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, ST_METHOD));
        drain_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cfg = '{2, 2, 2, 2, 3, 1};
                1: cfg = '{256, 2, 4096, 3, 4, 1};
                2: cfg = '{2, 256, 2, 4096, 1, 1};
                3: cfg = '{0, 511, 8191, 0, 0, 1};     // sizes and channels all clamped
                4: cfg = '{7, 5, 13, 9, 7, 1};
                5: cfg = '{3, 3, 5, 5, 4, 0};
                6: cfg = '{3, 3, 5, 5, 4, 255};
                7: cfg = '{256, 256, 4095, 4095, 2, 1};
                default: begin
                    cfg[0] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                                       : $urandom_range(2, 12);
                    cfg[1] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                                       : $urandom_range(2, 12);
                    cfg[2] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                       : $urandom_range(2, 40);
                    cfg[3] = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                       : $urandom_range(2, 40);
                    cfg[4] = $urandom_range(0, 7);
                    cfg[5] = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : 1;
                end
            endcase
            write_reg(CFG_SRC_W, cfg[0]);
            write_reg(CFG_SRC_H, cfg[1]);
            write_reg(CFG_DST_W, cfg[2]);
            write_reg(CFG_DST_H, cfg[3]);
            write_reg(CFG_CHAN, cfg[4]);
            write_reg(CFG_METHOD, cfg[5]);

            gmax = (ph % 3 == 0) ? 0 : 11;
            rx_max = (ph % 4 == 1) ? 0 : 11;
            n_items = 150;
            base = n_sent;
            paused = 1'b0;
            // neighbour fills count towards the phase budget
            while (n_sent - base < n_items) begin
                if (ph == 8 && n_sent - base >= 20) rx_hold_req = 1'b1;
                if (ph == 9 && n_sent - base >= 75 && !paused) begin
                    paused = 1'b1;
                    gap(1);
                    wait (pending_pixels.size() == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    it = rand_load($urandom_range(0, clampi(reg_sh, 2, 256) - 1),
                                   $urandom_range(0, clampi(reg_sw, 2, 256) - 1));
                end else if (pick < 14) begin
                    it = rand_load($urandom_range(0, 4095), $urandom_range(0, 4095));
                end else begin
                    if (pick < 20) begin
                        row = $urandom_range(0, 4095);
                        col = $urandom_range(0, 4095);
                    end else begin
                        row = $urandom_range(0, clampi(reg_dh, 2, 4096) - 1);
                        col = $urandom_range(0, clampi(reg_dw, 2, 4096) - 1);
                    end
                    if (reg_meth[7:0] == METHOD_BILINEAR && in_dst(row, col))
                        fill_neighbours(row, col, gmax);
                    it = rand_load(row, col);
                    it.mode = 1'b1;
                end
                send_beat(it, 1'b0, '0);
                gap($urandom_range(0, gmax));
            end
            drain_idle();
        end

        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("bilinear_image_scaler_core regression: pass");
        end else begin
            $display("bilinear_image_scaler_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bis_pkg.sv
hw/rtl/bis_div.sv
hw/rtl/bis_bank.sv
hw/rtl/bis_lane.sv
hw/rtl/bilinear_image_scaler_core.sv
test/tb_bilinear_image_scaler_core.sv
